// File: rtl/hsvrgb_pkg.sv
// Shared types and constants for the HSV to RGB converter pipeline.
package hsvrgb_pkg;

    localparam int HUE_W      = 15;
    localparam int CH_W       = 8;
    localparam int NUM_STAGES = 6;
    localparam int Q60_W      = 10;
    localparam int X_W        = 20;

    // degrees per sector and reciprocal constants for division by constants
    localparam int SECTOR_DEG  = 60;
    localparam int RECIP_15    = 69906;   // ceil(2^20 / 15)
    localparam int RECIP_6     = 683;     // ceil(2^12 / 6)
    localparam int DIV_3825    = 3825;    // 255 * 60 / 4
    localparam int RECIP_3825  = 4386;    // floor(2^24 / 3825)
    localparam int CH_MAX      = 255;

    typedef logic [NUM_STAGES-1:0] stage_vec_t;

    typedef enum logic [2:0] {
        SEC_R_Y = 3'd0,
        SEC_Y_G = 3'd1,
        SEC_G_C = 3'd2,
        SEC_C_B = 3'd3,
        SEC_B_M = 3'd4,
        SEC_M_R = 3'd5
    } sector_t;

endpackage

// File: rtl/hsvrgb_sector.sv
// Stages 1-2: split hue into a sector (0..5) and the remainder within the sector.
module hsvrgb_sector #(
    parameter int HUE_FRAC_BITS = 6
) (
    input  logic                          clk,
    input  hsvrgb_pkg::stage_vec_t        en,
    input  logic [hsvrgb_pkg::HUE_W-1:0]  hue,
    input  logic [hsvrgb_pkg::CH_W-1:0]   saturation,
    input  logic [hsvrgb_pkg::CH_W-1:0]   brightness,
    output logic [HUE_FRAC_BITS+5:0]      rem,
    output hsvrgb_pkg::sector_t           sector,
    output logic [hsvrgb_pkg::CH_W-1:0]   sat_out,
    output logic [hsvrgb_pkg::CH_W-1:0]   val_out
);
    import hsvrgb_pkg::*;

    localparam int REM_W = HUE_FRAC_BITS + 6;

    logic [HUE_W-1:0] deg_in;
    logic [29:0]      q_prod;
    logic [Q60_W-1:0] q60_next;
    logic [HUE_W-1:0] hue_s1_reg;
    logic [Q60_W-1:0] q60_s1_reg;
    logic [CH_W-1:0]  sat_s1_reg;
    logic [CH_W-1:0]  val_s1_reg;

    logic [HUE_W-1:0] deg_s1;
    logic [HUE_W-1:0] deg_diff;
    logic [HUE_W-1:0] frac_mask;
    logic [REM_W-1:0] rem_next;
    logic [19:0]      q6_prod;
    logic [7:0]       q6;
    logic [Q60_W-1:0] sec_wide;
    sector_t          sector_next;

    logic [REM_W-1:0] rem_s2_reg;
    sector_t          sector_s2_reg;
    logic [CH_W-1:0]  sat_s2_reg;
    logic [CH_W-1:0]  val_s2_reg;

    // whole degrees / 60 = (deg / 4) / 15, by reciprocal
    assign deg_in   = hue >> HUE_FRAC_BITS;
    assign q_prod   = 30'(deg_in[HUE_W-1:2]) * 30'(RECIP_15);
    assign q60_next = q_prod[29:20];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            hue_s1_reg <= hue;
            q60_s1_reg <= q60_next;
            sat_s1_reg <= saturation;
            val_s1_reg <= brightness;
        end
    end

    always_comb
    begin
        deg_s1    = hue_s1_reg >> HUE_FRAC_BITS;
        deg_diff  = deg_s1 - HUE_W'(q60_s1_reg) * HUE_W'(SECTOR_DEG);
        frac_mask = (HUE_W'(1) << HUE_FRAC_BITS) - HUE_W'(1);
        rem_next  = (REM_W'(deg_diff[5:0]) << HUE_FRAC_BITS)
                  | REM_W'(hue_s1_reg & frac_mask);
        // sector = (whole sectors) mod 6
        q6_prod     = 20'(q60_s1_reg) * 20'(RECIP_6);
        q6          = q6_prod[19:12];
        sec_wide    = q60_s1_reg - Q60_W'(q6) * Q60_W'(6);
        sector_next = sector_t'(sec_wide[2:0]);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            rem_s2_reg    <= rem_next;
            sector_s2_reg <= sector_next;
            sat_s2_reg    <= sat_s1_reg;
            val_s2_reg    <= val_s1_reg;
        end
    end

    assign rem     = rem_s2_reg;
    assign sector  = sector_s2_reg;
    assign sat_out = sat_s2_reg;
    assign val_out = val_s2_reg;

endmodule

// File: rtl/hsvrgb_scale.sv
// Stages 3-6: form p, q and t, divide by the constant denominators, select channels.
module hsvrgb_scale #(
    parameter int HUE_FRAC_BITS = 6
) (
    input  logic                          clk,
    input  hsvrgb_pkg::stage_vec_t        en,
    input  logic [HUE_FRAC_BITS+5:0]      rem,
    input  hsvrgb_pkg::sector_t           sector,
    input  logic [hsvrgb_pkg::CH_W-1:0]   saturation,
    input  logic [hsvrgb_pkg::CH_W-1:0]   brightness,
    output logic [hsvrgb_pkg::CH_W-1:0]   red,
    output logic [hsvrgb_pkg::CH_W-1:0]   green,
    output logic [hsvrgb_pkg::CH_W-1:0]   blue
);
    import hsvrgb_pkg::*;

    localparam int REM_W        = HUE_FRAC_BITS + 6;
    localparam int RS_W         = REM_W + 8;
    localparam int DEN_W        = HUE_FRAC_BITS + 14;
    localparam int PROD_W       = DEN_W + 8;
    localparam int SECTOR_UNITS = SECTOR_DEG << HUE_FRAC_BITS;
    localparam int DEN          = 255 * SECTOR_UNITS;

    function automatic logic [CH_W-1:0] limit_ch(input logic [8:0] x);
        logic [CH_W-1:0] res;
        res = (x > 9'(CH_MAX)) ? CH_W'(CH_MAX) : x[CH_W-1:0];
        return res;
    endfunction

    // stage 3
    logic [RS_W-1:0]  rs_s3_reg, ts_s3_reg;
    logic [15:0]      pn_s3_reg;
    logic [REM_W-1:0] drem;
    sector_t          sec_s3_reg;
    logic [CH_W-1:0]  sat_s3_reg, val_s3_reg;

    assign drem = REM_W'(SECTOR_UNITS) - rem;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            rs_s3_reg  <= RS_W'(rem) * RS_W'(saturation);
            ts_s3_reg  <= RS_W'(drem) * RS_W'(saturation);
            pn_s3_reg  <= 16'(brightness) * 16'(8'd255 - saturation);
            sec_s3_reg <= sector;
            sat_s3_reg <= saturation;
            val_s3_reg <= brightness;
        end
    end

    // stage 4
    logic [DEN_W-1:0]  qn, tn;
    logic [16:0]       p_sum;
    logic [PROD_W-1:0] qprod_s4_reg, tprod_s4_reg;
    logic [CH_W-1:0]   p_s4_reg;
    sector_t           sec_s4_reg;
    logic [CH_W-1:0]   sat_s4_reg, val_s4_reg;

    assign qn    = DEN_W'(DEN) - DEN_W'(rs_s3_reg);
    assign tn    = DEN_W'(DEN) - DEN_W'(ts_s3_reg);
    // exact x / 255 for x below 65535
    assign p_sum = 17'(pn_s3_reg) + 17'(pn_s3_reg >> 8) + 17'd1;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            qprod_s4_reg <= PROD_W'(val_s3_reg) * PROD_W'(qn);
            tprod_s4_reg <= PROD_W'(val_s3_reg) * PROD_W'(tn);
            p_s4_reg     <= p_sum[15:8];
            sec_s4_reg   <= sec_s3_reg;
            sat_s4_reg   <= sat_s3_reg;
            val_s4_reg   <= val_s3_reg;
        end
    end

    // stage 5: estimate x / 3825, low by at most one
    logic [X_W-1:0]  xq, xt;
    logic [32:0]     qe_prod, te_prod;
    logic [X_W-1:0]  xq_s5_reg, xt_s5_reg;
    logic [CH_W-1:0] qe_s5_reg, te_s5_reg;
    logic [CH_W-1:0] p_s5_reg;
    sector_t         sec_s5_reg;
    logic [CH_W-1:0] sat_s5_reg, val_s5_reg;

    assign xq      = X_W'(qprod_s4_reg >> (HUE_FRAC_BITS + 2));
    assign xt      = X_W'(tprod_s4_reg >> (HUE_FRAC_BITS + 2));
    assign qe_prod = 33'(xq) * 33'(RECIP_3825);
    assign te_prod = 33'(xt) * 33'(RECIP_3825);

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            xq_s5_reg  <= xq;
            xt_s5_reg  <= xt;
            qe_s5_reg  <= qe_prod[31:24];
            te_s5_reg  <= te_prod[31:24];
            p_s5_reg   <= p_s4_reg;
            sec_s5_reg <= sec_s4_reg;
            sat_s5_reg <= sat_s4_reg;
            val_s5_reg <= val_s4_reg;
        end
    end

    // stage 6: correct quotient, select by sector
    logic [X_W-1:0]  rq, rt;
    logic [CH_W-1:0] q_ch, t_ch, p_ch, v_ch;
    logic [CH_W-1:0] red_next, green_next, blue_next;
    logic [CH_W-1:0] red_reg, green_reg, blue_reg;

    always_comb
    begin
        rq   = xq_s5_reg - X_W'(qe_s5_reg) * X_W'(DIV_3825);
        rt   = xt_s5_reg - X_W'(te_s5_reg) * X_W'(DIV_3825);
        q_ch = limit_ch(9'(qe_s5_reg) + 9'(rq >= X_W'(DIV_3825)));
        t_ch = limit_ch(9'(te_s5_reg) + 9'(rt >= X_W'(DIV_3825)));
        p_ch = p_s5_reg;
        v_ch = val_s5_reg;
        unique case (sec_s5_reg)
            SEC_R_Y: begin red_next = v_ch; green_next = t_ch; blue_next = p_ch; end
            SEC_Y_G: begin red_next = q_ch; green_next = v_ch; blue_next = p_ch; end
            SEC_G_C: begin red_next = p_ch; green_next = v_ch; blue_next = t_ch; end
            SEC_C_B: begin red_next = p_ch; green_next = q_ch; blue_next = v_ch; end
            SEC_B_M: begin red_next = t_ch; green_next = p_ch; blue_next = v_ch; end
            default: begin red_next = v_ch; green_next = p_ch; blue_next = q_ch; end
        endcase
        // zero saturation is a gray at the value level
        if (sat_s5_reg == '0)
        begin
            red_next   = v_ch;
            green_next = v_ch;
            blue_next  = v_ch;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule

// File: rtl/hsv_to_rgb_converter_core.sv
// Top level: six-stage HSV to RGB pipeline with per-stage valid and stall control.
//
//  channel | valid     | ready     | payload
//  --------+-----------+-----------+-------------------------------
//  HSV in  | hsv_valid | hsv_ready | hue, saturation, brightness
//  RGB out | rgb_valid | rgb_ready | red, green, blue
//
// One item per cycle sustained while rgb_ready stays high; rgb_valid rises once an
// accepted item has passed through the six register stages (sector split, products,
// constant-reciprocal division and its correction).
// rst_n clears only the stage valid bits; payload registers are not reset.
// A stage holds while the one after it is full and stalled; empty stages
// still fill, so hsv_ready stays high until every stage holds an item.
module hsv_to_rgb_converter_core #(
    parameter int HUE_FRAC_BITS = 6
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         hsv_valid,
    output logic                         hsv_ready,
    input  logic [hsvrgb_pkg::HUE_W-1:0] hue,
    input  logic [hsvrgb_pkg::CH_W-1:0]  saturation,
    input  logic [hsvrgb_pkg::CH_W-1:0]  brightness,
    output logic                         rgb_valid,
    input  logic                         rgb_ready,
    output logic [hsvrgb_pkg::CH_W-1:0]  red,
    output logic [hsvrgb_pkg::CH_W-1:0]  green,
    output logic [hsvrgb_pkg::CH_W-1:0]  blue
);
    import hsvrgb_pkg::*;

    stage_vec_t valid_reg;
    stage_vec_t valid_next;
    stage_vec_t adv;

    logic [HUE_FRAC_BITS+5:0] rem_s2;
    sector_t                  sector_s2;
    logic [CH_W-1:0]          sat_s2;
    logic [CH_W-1:0]          val_s2;

    // a stage loads when it is empty or its contents move on
    always_comb
    begin
        adv[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || rgb_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
        valid_next = valid_reg;
        if (adv[0])
        begin
            valid_next[0] = hsv_valid;
        end
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            if (adv[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign hsv_ready = adv[0];
    assign rgb_valid = valid_reg[NUM_STAGES-1];

    hsvrgb_sector #(
        .HUE_FRAC_BITS (HUE_FRAC_BITS)
    ) u_sector (
        .clk        (clk),
        .en         (adv),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .rem        (rem_s2),
        .sector     (sector_s2),
        .sat_out    (sat_s2),
        .val_out    (val_s2)
    );

    hsvrgb_scale #(
        .HUE_FRAC_BITS (HUE_FRAC_BITS)
    ) u_scale (
        .clk        (clk),
        .en         (adv),
        .rem        (rem_s2),
        .sector     (sector_s2),
        .saturation (sat_s2),
        .brightness (val_s2),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

endmodule

// File: sim/tb_hsv_to_rgb_converter_core.sv
// Self-checking testbench for the HSV to RGB converter pipeline.
module tb_hsv_to_rgb_converter_core;
    timeunit 1ns;
    timeprecision 1ps;

    import hsvrgb_pkg::*;

    localparam int HUE_FRAC_BITS = 6;
    localparam int SECTOR_UNITS  = SECTOR_DEG << HUE_FRAC_BITS;
    localparam int FULL_TURN     = 6 * SECTOR_UNITS;
    localparam int HUE_MAX       = (1 << HUE_W) - 1;
    localparam int NUM_RANDOM    = 1600;
    localparam int QUIET_TAIL    = 300;
    localparam int STALL_LIMIT   = 2000;

    typedef logic [HUE_W-1:0] hue_t;
    typedef logic [CH_W-1:0]  chan_t;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
    } rgb_t;

    class rgb_scoreboard;
        rgb_t pending[$];
        int   errors;
        int   colors;
        int   grays;
        int   wrapped;
        int   checked;

        function new();
            errors  = 0;
            colors  = 0;
            grays   = 0;
            wrapped = 0;
            checked = 0;
        endfunction

        function chan_t limit_chan(longint unsigned x);
            return (x > CH_MAX) ? chan_t'(CH_MAX) : chan_t'(x);
        endfunction

        function rgb_t convert_color(hue_t h, chan_t s, chan_t v);
            longint unsigned sat;
            longint unsigned val;
            longint unsigned turn_pos;
            longint unsigned rem;
            longint unsigned den;
            chan_t           pc;
            chan_t           qc;
            chan_t           tc;
            chan_t           vc;
            sector_t         sec;
            rgb_t            c;
            sat = 64'(s);
            val = 64'(v);
            if (sat == 0)
            begin
                c.red   = v;
                c.green = v;
                c.blue  = v;
                return c;
            end
            turn_pos = longint'(h) % FULL_TURN;
            sec      = sector_t'(turn_pos / SECTOR_UNITS);
            rem      = turn_pos % SECTOR_UNITS;
            den      = 64'(CH_MAX * SECTOR_UNITS);
            pc = limit_chan(val * (CH_MAX - sat) / CH_MAX);
            qc = limit_chan(val * (den - rem * sat) / den);
            tc = limit_chan(val * (den - (SECTOR_UNITS - rem) * sat) / den);
            vc = v;
            case (sec)
                SEC_R_Y: c = '{vc, tc, pc};
                SEC_Y_G: c = '{qc, vc, pc};
                SEC_G_C: c = '{pc, vc, tc};
                SEC_C_B: c = '{pc, qc, vc};
                SEC_B_M: c = '{tc, pc, vc};
                default: c = '{vc, pc, qc};
            endcase
            return c;
        endfunction

        function void note_hsv(hue_t h, chan_t s, chan_t v);
            pending.push_back(convert_color(h, s, v));
            colors++;
            if (s == 0)
                grays++;
            if (h >= FULL_TURN)
                wrapped++;
        endfunction

        function void check_rgb(chan_t r, chan_t g, chan_t b);
            rgb_t want;
            if (pending.size() == 0)
            begin
                $error("rgb item with none expected: red %0d green %0d blue %0d", r, g, b);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (r !== want.red)
            begin
                $error("red: expected %0d, actual %0d", want.red, r);
                errors++;
            end
            if (g !== want.green)
            begin
                $error("green: expected %0d, actual %0d", want.green, g);
                errors++;
            end
            if (b !== want.blue)
            begin
                $error("blue: expected %0d, actual %0d", want.blue, b);
                errors++;
            end
        endfunction
    endclass

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  hsv_valid = 1'b0;
    logic  hsv_ready;
    hue_t  hue = '0;
    chan_t saturation = '0;
    chan_t brightness = '0;
    logic  rgb_valid;
    logic  rgb_ready = 1'b0;
    chan_t red;
    chan_t green;
    chan_t blue;

    bit src_gaps    = 1'b0;
    bit sink_stalls = 1'b0;

    rgb_scoreboard sb = new();

    hsv_to_rgb_converter_core #(
        .HUE_FRAC_BITS(HUE_FRAC_BITS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .hsv_valid (hsv_valid),
        .hsv_ready (hsv_ready),
        .hue       (hue),
        .saturation(saturation),
        .brightness(brightness),
        .rgb_valid (rgb_valid),
        .rgb_ready (rgb_ready),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && hsv_valid && hsv_ready)
            sb.note_hsv(hue, saturation, brightness);
        if (rst_n && rgb_valid && rgb_ready)
            sb.check_rgb(red, green, blue);
    end

    // output side: ready runs and stall bursts
    initial
    begin
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (sink_stalls && $urandom_range(0, 2) == 0)
            begin
                rgb_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge clk);
            end
            else
            begin
                rgb_ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(negedge clk);
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((hsv_valid && hsv_ready) || (rgb_valid && rgb_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("no handshake for %0d cycles", STALL_LIMIT);
        $display("hsv_to_rgb_converter_core: mismatch");
        $finish;
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_hsv(input hue_t h, input chan_t s, input chan_t v);
        if (src_gaps && $urandom_range(0, 3) == 0)
        begin
            hsv_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        hsv_valid  <= 1'b1;
        hue        <= h;
        saturation <= s;
        brightness <= v;
        do
            @(posedge clk);
        while (!hsv_ready);
        @(negedge clk);
    endtask

    function automatic chan_t pick_chan();
        case ($urandom_range(0, 9))
            0:       return chan_t'(0);
            1:       return chan_t'(CH_MAX);
            2:       return chan_t'(1);
            default: return chan_t'($urandom_range(0, CH_MAX));
        endcase
    endfunction

    function automatic hue_t pick_hue();
        case ($urandom_range(0, 9))
            0:       return hue_t'($urandom_range(FULL_TURN + 1, HUE_MAX));
            1:       return hue_t'($urandom_range(1, 6) * SECTOR_UNITS - 1
                                   + $urandom_range(0, 2));
            default: return hue_t'($urandom_range(0, FULL_TURN));
        endcase
    endfunction

    initial
    begin
        hue_t  dir_hue[$];
        chan_t dir_sat[$];
        chan_t dir_val[$];
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // gray, full scale, 360 wrap, all-ones hue, sector edges, dark
        dir_hue = '{0, 0, 12345, 0, hue_t'(FULL_TURN), hue_t'(FULL_TURN - 1),
                    hue_t'(HUE_MAX), hue_t'(HUE_MAX), 1920, 1920, 5000,
                    hue_t'(FULL_TURN + 2 * SECTOR_UNITS + 7)};
        dir_sat = '{0, 0, 0, 255, 255, 255, 255, 1, 255, 1, 255, 128};
        dir_val = '{0, 255, 128, 255, 255, 255, 255, 1, 255, 255, 0, 77};
        for (int k = 1; k < 6; k++)
        begin
            dir_hue.push_back(hue_t'(k * SECTOR_UNITS));
            dir_sat.push_back(8'd200);
            dir_val.push_back(8'd255);
            dir_hue.push_back(hue_t'(k * SECTOR_UNITS - 1));
            dir_sat.push_back(8'd200);
            dir_val.push_back(8'd255);
        end
        foreach (dir_hue[i])
            send_hsv(dir_hue[i], dir_sat[i], dir_val[i]);

        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            if (n % 100 == 0)
            begin
                src_gaps    = (n < NUM_RANDOM - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
                sink_stalls = (n < NUM_RANDOM - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            end
            send_hsv(pick_hue(), pick_chan(), pick_chan());
        end
        hsv_valid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (4 * NUM_STAGES) @(posedge clk);
        if (sb.pending.size() != 0)
        begin
            $error("%0d rgb items never arrived", sb.pending.size());
            sb.errors++;
        end

        $display("converted %0d colors, %0d rgb items compared", sb.colors, sb.checked);
        $display("of these %0d were gray and %0d had hue at or beyond a full turn",
                 sb.grays, sb.wrapped);
        if (sb.errors == 0)
            $display("hsv_to_rgb_converter_core: match");
        else
            $display("hsv_to_rgb_converter_core: mismatch");
        $finish;
    end

endmodule
